>>> rtl/prlp_pkg.sv
// Types, constants and the digit decoder shared by the radix literal parser.
package prlp_pkg;

  localparam int unsigned MaxLen = 64;
  localparam logic [7:0] LenCap = (MaxLen < 127) ? 8'(MaxLen) : 8'd127;

  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChLittle = 8'h4C;
  localparam logic [7:0] ChBig    = 8'h42;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] CaseMask = 8'hDF;
  localparam logic [7:0] NoDigit  = 8'hFF;

  localparam logic [6:0] PosOrder = 7'd0;
  localparam logic [6:0] PosBase  = 7'd1;
  localparam logic [6:0] PosColon = 7'd2;
  localparam logic [6:0] HdrLen   = 7'd3;
  localparam logic [6:0] CntMax   = 7'd127;

  typedef struct packed {
    logic [6:0]  pos;
    logic        little;
    logic [5:0]  radix;
    logic [63:0] acc;
    logic [63:0] weight;
    logic [6:0]  count;
    logic        stopped;
    logic        bad;
  } st_t;

  localparam st_t StReset = '{
    pos: 7'd0, little: 1'b0, radix: 6'd0, acc: 64'd0,
    weight: 64'd1, count: 7'd0, stopped: 1'b0, bad: 1'b0
  };

  typedef struct packed {
    logic [63:0] value;
    logic [6:0]  len;
    logic        ok;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       last;
  } item_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    case (c) inside
      [8'h30:8'h39]: d = c - 8'h30;
      [8'h41:8'h5A]: d = c - 8'h37;
      [8'h61:8'h7A]: d = c - 8'h57;
      default:       d = NoDigit;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/prefixed_radix_literal_parser.sv
// Top level of the radix literal parser: input register, parse step, result register.
// A request is held in the input register, and its result is then loaded into the result register.
// Throughput: one character per cycle unless a last one waits; the 64x6 multiply-add of the accumulator sets the path.
// A character with no result advances even while the result register is stalled.
// Reset clears the parse state (weight to one) and both valid flags.
module prefixed_radix_literal_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  input  logic               last_char_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] value_o,
  output logic [6:0]         consumed_length_o,
  output logic               valid_res_o
);
  import prlp_pkg::*;

  item_t item;
  res_t  res_c, res_q;
  logic  adv, free, res_load;

  assign adv      = item.valid && (!item.last || free);
  assign res_load = adv && item.last;

  prlp_in_stage u_in (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .char_code_i, .last_char_i,
    .adv_i(adv), .item_o(item)
  );

  prlp_core u_core (
    .clk_i, .rst_ni, .item_i(item), .adv_i(adv), .res_o(res_c)
  );

  prlp_out_stage u_out (
    .clk_i, .rst_ni, .load_i(res_load), .res_i(res_c), .free_o(free),
    .out_valid_o, .out_stall_i, .res_o(res_q)
  );

  assign value_o           = res_q.value;
  assign consumed_length_o = res_q.len;
  assign valid_res_o       = res_q.ok;

  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |-> consumed_length_o >= 7'd4)
    else $error("valid result with short length");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> value_o == 64'sd0 && consumed_length_o == 7'd0)
    else $error("invalid result not cleared");

  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item.valid && !adv |=> item.valid && $stable(item.ch) && $stable(item.last))
    else $error("stalled character lost");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !out_valid_o || !out_stall_i)
    else $error("result register overwritten");

endmodule

>>> rtl/prlp_in_stage.sv
// Input register of the radix literal parser.
module prlp_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     char_code_i,
  input  logic           last_char_i,
  input  logic           adv_i,
  output prlp_pkg::item_t item_o
);
  import prlp_pkg::*;

  logic       v_q, v_d;
  logic [7:0] ch_q;
  logic       last_q;
  logic       load;

  assign in_stall_o = v_q && !adv_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    v_d = v_q;
    if (load) begin
      v_d = 1'b1;
    end else if (adv_i) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ch_q   <= char_code_i;
      last_q <= last_char_i;
    end
  end

  assign item_o = '{valid: v_q, ch: ch_q, last: last_q};

endmodule

>>> rtl/prlp_core.sv
// Parse state and per-character update of the radix literal parser.
module prlp_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  prlp_pkg::item_t item_i,
  input  logic            adv_i,
  output prlp_pkg::res_t  res_o
);
  import prlp_pkg::*;

  st_t         st_q, st_d, nx;
  logic [7:0]  d;
  logic [63:0] mul_a_op;
  logic [69:0] mul_a, mul_b;
  logic [7:0]  len_sum;

  always_comb begin
    nx       = st_q;
    d        = digit_value(item_i.ch);
    mul_a_op = st_q.little ? st_q.weight : st_q.acc;
    mul_a    = 70'(mul_a_op) * 70'(st_q.radix);
    mul_b    = 70'(st_q.weight) * 70'(d[5:0]);
    case (st_q.pos)
      PosOrder: begin
        if ((item_i.ch & CaseMask) == ChLittle) begin
          nx.little = 1'b1;
        end else if ((item_i.ch & CaseMask) == ChBig) begin
          nx.little = 1'b0;
        end else begin
          nx.bad = 1'b1;
        end
      end
      PosBase: begin
        if (d == NoDigit) begin
          nx.bad = 1'b1;
        end else begin
          nx.radix = d[5:0] + 6'd1;
        end
      end
      PosColon: begin
        if (item_i.ch != ChColon) begin
          nx.bad = 1'b1;
        end
      end
      default: begin
        if (!st_q.stopped && !st_q.bad) begin
          if (item_i.ch == ChUnder) begin
            if (st_q.count != CntMax) nx.count = st_q.count + 7'd1;
          end else if (d < {2'b00, st_q.radix}) begin
            if (st_q.little) begin
              nx.acc    = st_q.acc + mul_b[63:0];
              nx.weight = mul_a[63:0];
            end else begin
              nx.acc = mul_a[63:0] + {58'd0, d[5:0]};
            end
            if (st_q.count != CntMax) nx.count = st_q.count + 7'd1;
          end else begin
            nx.stopped = 1'b1;
          end
        end
      end
    endcase
    if (st_q.pos != CntMax) nx.pos = st_q.pos + 7'd1;
  end

  always_comb begin
    st_d = st_q;
    if (adv_i) begin
      st_d = item_i.last ? StReset : nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StReset;
    end else begin
      st_q <= st_d;
    end
  end

  assign len_sum = {1'b0, nx.count} + {1'b0, HdrLen};

  always_comb begin
    res_o.ok    = (st_q.pos >= HdrLen) && !nx.bad && (nx.count != 7'd0);
    res_o.value = res_o.ok ? nx.acc : 64'd0;
    res_o.len   = 7'd0;
    if (res_o.ok) begin
      res_o.len = (len_sum > LenCap) ? LenCap[6:0] : len_sum[6:0];
    end
  end

endmodule

>>> rtl/prlp_out_stage.sv
// Result register of the radix literal parser.
module prlp_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  prlp_pkg::res_t res_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output prlp_pkg::res_t res_o
);
  import prlp_pkg::*;

  logic ov_q, ov_d;
  res_t res_q;

  assign free_o = !ov_q || !out_stall_i;

  always_comb begin
    ov_d = ov_q;
    if (load_i) begin
      ov_d = 1'b1;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = ov_q;
  assign res_o       = res_q;

endmodule

>>> tb/radix_literal_check_pkg.sv
// Parse predictor and result scoreboard for the radix literal parser testbench.
package radix_literal_check_pkg;
  import prlp_pkg::*;

  class radix_literal_checker;
    logic [6:0]  at_pos;
    logic        lsd_first;
    logic [5:0]  base;
    logic [63:0] sum;
    logic [63:0] weight;
    logic [6:0]  taken;
    logic        halted;
    logic        hdr_bad;

    res_t expected_parses[$];
    int   mismatches;
    int   parses_checked;
    int   good_parses;
    int   literals;

    function new();
      clear();
      mismatches     = 0;
      parses_checked = 0;
      good_parses    = 0;
      literals       = 0;
    endfunction

    function void clear();
      at_pos    = '0;
      lsd_first = 1'b0;
      base      = '0;
      sum       = '0;
      weight    = 64'd1;
      taken     = '0;
      halted    = 1'b0;
      hdr_bad   = 1'b0;
    endfunction

    static function logic [7:0] digit_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
      if (c >= 8'h41 && c <= 8'h5A) return c - 8'h41 + 8'd10;
      if (c >= 8'h61 && c <= 8'h7A) return c - 8'h61 + 8'd10;
      return NoDigit;
    endfunction

    function int pending();
      return expected_parses.size();
    endfunction

    // Advance the parse by one accepted request; queue a result on the last character.
    function void note_char(logic [7:0] ch, logic is_last);
      logic [6:0] here;
      logic [7:0] dv;
      logic [7:0] span;
      res_t       r;
      here = at_pos;
      case (here)
        PosOrder: begin
          if ((ch & CaseMask) == ChLittle) lsd_first = 1'b1;
          else if ((ch & CaseMask) == ChBig) lsd_first = 1'b0;
          else hdr_bad = 1'b1;
        end
        PosBase: begin
          dv = digit_of(ch);
          if (dv == NoDigit) hdr_bad = 1'b1;
          else base = 6'(dv + 8'd1);
        end
        PosColon: begin
          if (ch != ChColon) hdr_bad = 1'b1;
        end
        default: begin
          if (!halted && !hdr_bad) begin
            if (ch == ChUnder) begin
              if (taken != CntMax) taken++;
            end else begin
              dv = digit_of(ch);
              if (dv < {2'b00, base}) begin
                if (lsd_first) begin
                  sum    = sum + 64'(dv) * weight;
                  weight = weight * 64'(base);
                end else begin
                  sum = sum * 64'(base) + 64'(dv);
                end
                if (taken != CntMax) taken++;
              end else begin
                halted = 1'b1;
              end
            end
          end
        end
      endcase
      if (at_pos != CntMax) at_pos++;
      if (is_last) begin
        r.ok  = (here >= HdrLen) && !hdr_bad && (taken != '0);
        span  = {1'b0, taken} + 8'd3;
        if (span > LenCap) span = LenCap;
        r.value = r.ok ? sum : '0;
        r.len   = r.ok ? span[6:0] : '0;
        expected_parses.push_back(r);
        literals++;
        clear();
      end
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH %s", $time, what);
      mismatches++;
    endtask

    task check_parse(logic [63:0] value, logic [6:0] len, logic ok);
      res_t want;
      if (expected_parses.size() == 0) begin
        report($sformatf("unexpected result value=%h len=%0d ok=%b", value, len, ok));
        return;
      end
      want = expected_parses.pop_front();
      parses_checked++;
      if (ok) good_parses++;
      if (value !== want.value)
        report($sformatf("value %h, want %h", value, want.value));
      if (len !== want.len)
        report($sformatf("consumed_length %0d, want %0d", len, want.len));
      if (ok !== want.ok)
        report($sformatf("valid_res %b, want %b", ok, want.ok));
    endtask
  endclass

endpackage

>>> tb/testbench.sv
// Top-level testbench for the radix literal parser: stimulus, handshakes and checking.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import prlp_pkg::*;
  import radix_literal_check_pkg::*;

  typedef logic [7:0] char_q_t[$];

  localparam int PhaseChars  = 490;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 16;
  localparam int HoldCycles  = 400;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [7:0]         char_code       = '0;
  logic               last_char       = 1'b0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic signed [63:0] value;
  logic [6:0]         consumed_length;
  logic               valid_res;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_orders    = 0;
  int chars_sent     = 0;

  radix_literal_checker parse_model = new();

  prefixed_radix_literal_parser u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .char_code_i       (char_code),
    .last_char_i       (last_char),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .value_o           (value),
    .consumed_length_o (consumed_length),
    .valid_res_o       (valid_res)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver: checks results, stalls at random, and serves long hold-offs
  always @(posedge clk_i) begin : receiver
    int hold_served;
    int hold_left;
    if (rst_ni && out_valid && !out_stall)
      parse_model.check_parse(value, consumed_length, valid_res);
    if (hold_served != hold_orders) begin
      hold_served = hold_orders;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin : watchdog
    for (int cyc = 0; cyc < CycleLimit; cyc++) @(posedge clk_i);
    $display("testbench failed");
    $finish;
  end

  task automatic send_char(input logic [7:0] ch, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    char_code <= ch;
    last_char <= is_last;
    do @(posedge clk_i); while (in_stall);
    parse_model.note_char(ch, is_last);
    chars_sent++;
  endtask

  task automatic send_literal(input char_q_t lit);
    for (int i = 0; i < lit.size(); i++) send_char(lit[i], i == lit.size() - 1);
  endtask

  function automatic char_q_t from_text(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] digit_char(int d);
    if (d < 10) return 8'h30 + 8'(d);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(d - 10);
  endfunction

  // mostly well-formed literals; some long, some broken, some plain noise
  function automatic char_q_t random_literal();
    char_q_t    lit;
    int         kind;
    int         count;
    int         top;
    logic [7:0] b;
    kind = $urandom_range(99);
    if (kind >= 90) begin
      count = $urandom_range(1, 8);
      repeat (count) lit.push_back(8'($urandom));
      return lit;
    end
    top = $urandom_range(35);
    case ($urandom_range(3))
      0:       lit.push_back(ChLittle);
      1:       lit.push_back(ChLittle | ~CaseMask);
      2:       lit.push_back(ChBig);
      default: lit.push_back(ChBig | ~CaseMask);
    endcase
    lit.push_back(digit_char(top));
    lit.push_back(ChColon);
    if (kind < 4) count = $urandom_range(40, 135);
    else count = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12);
    for (int i = 0; i < count; i++)
      lit.push_back(($urandom_range(9) == 0) ? ChUnder : digit_char($urandom_range(top)));
    if ($urandom_range(2) == 0) begin
      do b = 8'($urandom);
      while (b == ChUnder || radix_literal_checker::digit_of(b) <= top);
      lit.push_back(b);
      repeat ($urandom_range(3)) lit.push_back(8'($urandom));
    end
    if (kind >= 75) begin
      if ($urandom_range(1) == 0) begin
        count = $urandom_range(1, 3);
        while (lit.size() > count) void'(lit.pop_back());
      end else begin
        lit[$urandom_range(2)] = 8'($urandom);
      end
    end
    return lit;
  endfunction

  initial begin : stimulus
    char_q_t lit;
    int      random_base;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_literal(from_text("b9:9"));
    send_literal(from_text("LZ:z_Z"));
    send_literal(from_text("B1:"));
    lit = from_text("?9:1");
    lit[0] = 8'h00;
    send_literal(lit);
    send_literal(from_text("L!:1"));
    lit = from_text("B1:?");
    lit[3] = 8'hFF;
    send_literal(lit);

    random_base = chars_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_orders++;
        end
        1: begin
          send_idle_pct  = 87;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 87;
        end
        default: begin
          send_idle_pct  = 14;
          recv_stall_pct = 14;
          hold_orders++;
        end
      endcase
      while (chars_sent < random_base + (phase + 1) * PhaseChars)
        send_literal(random_literal());
    end
    in_valid <= 1'b0;

    while (parse_model.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d literals in %0d characters; %0d results checked, %0d valid",
             parse_model.literals, chars_sent, parse_model.parses_checked,
             parse_model.good_parses);
    $display("idle mixes: none, sender-only, receiver-only, both; %0d long output hold-offs",
             hold_orders);
    if (parse_model.mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
